/* hdl/tcc_pkg.sv */
package tcc_pkg;

	// Screen geometry
	localparam int COLUMNS  = 80;
	localparam int ROWS     = 25;
	localparam int TAB_STOP = 8;
	localparam int CELLS    = ROWS * COLUMNS;

	// Widths
	localparam int COL_W   = $clog2(COLUMNS);
	localparam int ROW_W   = (ROWS > 2) ? $clog2(ROWS) : 1;
	localparam int ADDR_W  = $clog2(CELLS);
	localparam int CELL_W  = 16;
	localparam int ATTR_W  = 8;
	localparam int CHAR_W  = 8;
	localparam int FUNC_W  = 2;
	localparam int INDEX_W = 11;
	localparam int LOC_W   = 11;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Function codes
	localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;
	localparam logic [CHAR_W-1:0] BLANK_CHAR  = 8'h20;

	// Register map (word index within paddr)
	localparam logic [PADDR_W-3:0] REG_ATTR   = '0;
	localparam logic [ATTR_W-1:0]  ATTR_RESET = 8'h0F;

	// Useful addresses and limits
	localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
	localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] FILL_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
	localparam logic [ADDR_W-1:0] ROW_SPAN  = ADDR_W'(COLUMNS);

	// Tab table: for each column, the wrap flag and the next tab stop column.
	localparam int TAB_DEPTH = 2 ** COL_W;
	typedef logic [COL_W:0] tab_ent_t;
	typedef tab_ent_t tab_lut_t [TAB_DEPTH];

	function automatic tab_lut_t build_tab_lut();
		tab_lut_t lut;
		int       nxt;
		for (int i = 0; i < TAB_DEPTH; i++) begin
			nxt = i + TAB_STOP - (i % TAB_STOP);
			if (nxt >= COLUMNS) begin
				lut[i] = {1'b1, COL_W'(0)};
			end else begin
				lut[i] = {1'b0, COL_W'(nxt)};
			end
		end
		return lut;
	endfunction

	localparam tab_lut_t TAB_LUT = build_tab_lut();

	// Request from the sequencer to the screen memory
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CELL_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

/* hdl/tcc_cmd_if.sv */
interface tcc_cmd_if;
	import tcc_pkg::*;

	logic               valid;
	logic               ready;
	logic [FUNC_W-1:0]  func;
	logic [CHAR_W-1:0]  char_code;
	logic [INDEX_W-1:0] cell_index;

	modport source (output valid, func, char_code, cell_index, input ready);
	modport sink (input valid, func, char_code, cell_index, output ready);
endinterface

/* hdl/tcc_rsp_if.sv */
interface tcc_rsp_if;
	import tcc_pkg::*;

	logic              valid;
	logic              ready;
	logic [LOC_W-1:0]  cursor_pos;
	logic [CELL_W-1:0] cell_data;

	modport source (output valid, cursor_pos, cell_data, input ready);
	modport sink (input valid, cursor_pos, cell_data, output ready);
endinterface

/* hdl/tcc_ram.sv */
module tcc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hdl/tcc_ctrl.sv */
module tcc_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [tcc_pkg::ATTR_W-1:0]   attr,
	tcc_cmd_if.sink                      cmd,
	tcc_rsp_if.source                    rsp,
	output tcc_pkg::mem_req_t            mem_req,
	input  logic [tcc_pkg::CELL_W-1:0]   mem_rdata
);
	import tcc_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_READ = 5'b00010,
		ST_COPY = 5'b00100,
		ST_FILL = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t            state_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] src_q;
	logic [ADDR_W-1:0] fill_q;
	logic [CELL_W-1:0] data_q;
	logic              rsp_valid_q;
	logic [LOC_W-1:0]  loc_q;
	logic [CELL_W-1:0] cell_q;
	logic              copy_pend_s1;
	logic [ADDR_W-1:0] dst_s1;

	logic              accept;
	logic              in_range;
	logic [ADDR_W-1:0] cur_addr;
	logic [CELL_W-1:0] blank;
	tab_ent_t          tab_ent;
	logic [COL_W-1:0]  col_d;
	logic [ROW_W-1:0]  row_d;
	logic              advance;
	logic              print;
	logic              scroll;

	assign cmd.ready      = (state_q == ST_IDLE);
	assign accept         = cmd.valid && cmd.ready;
	assign in_range       = (32'(cmd.cell_index) < 32'(CELLS));
	assign cur_addr       = ADDR_W'(row_q) * ROW_SPAN + ADDR_W'(col_q);
	assign blank          = {attr, BLANK_CHAR};
	assign rsp.valid      = rsp_valid_q;
	assign rsp.cursor_pos = loc_q;
	assign rsp.cell_data  = cell_q;

	// Cursor movement for a put word
	always_comb begin
		col_d   = col_q;
		row_d   = row_q;
		advance = 1'b0;
		print   = 1'b0;
		tab_ent = TAB_LUT[col_q];
		priority if (cmd.char_code == CH_BS) begin
			if (col_q != '0) begin
				col_d = col_q - 1'b1;
			end
		end else if (cmd.char_code == CH_TAB) begin
			if (tab_ent[COL_W]) begin
				col_d   = '0;
				advance = 1'b1;
			end else begin
				col_d = tab_ent[COL_W-1:0];
			end
		end else if (cmd.char_code == CH_CR) begin
			col_d = '0;
		end else if (cmd.char_code == CH_LF) begin
			col_d   = '0;
			advance = 1'b1;
		end else if (cmd.char_code >= CH_PRINT_LO && cmd.char_code <= CH_PRINT_HI) begin
			print = 1'b1;
			if (col_q == COL_LAST) begin
				col_d   = '0;
				advance = 1'b1;
			end else begin
				col_d = col_q + 1'b1;
			end
		end else begin
			col_d = col_q;
		end
		scroll = advance && (row_q == ROW_LAST);
		if (advance && !scroll) begin
			row_d = row_q + 1'b1;
		end
	end

	// Memory port selection. A copy write follows its read in the next cycle and
	// takes the write port ahead of the blank fill.
	always_comb begin
		mem_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && cmd.func == FUNC_PUT && print) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = cur_addr;
					mem_req.wdata = {attr, cmd.char_code};
				end
				if (accept && cmd.func == FUNC_READ && in_range) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = ADDR_W'(cmd.cell_index);
				end
			end
			ST_COPY: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = src_q;
			end
			default: begin
				mem_req.re = 1'b0;
			end
		endcase
		if (copy_pend_s1) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = dst_s1;
			mem_req.wdata = mem_rdata;
		end else if (state_q == ST_FILL) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = fill_q;
			mem_req.wdata = blank;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			col_q        <= '0;
			row_q        <= '0;
			src_q        <= '0;
			fill_q       <= '0;
			data_q       <= '0;
			rsp_valid_q  <= 1'b0;
			loc_q        <= '0;
			cell_q       <= '0;
			copy_pend_s1 <= 1'b0;
			dst_s1       <= '0;
		end else begin
			copy_pend_s1 <= (state_q == ST_COPY);
			dst_s1       <= src_q - ROW_SPAN;
			if (state_q == ST_DONE && (!rsp_valid_q || rsp.ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						data_q <= '0;
						unique case (cmd.func)
							FUNC_PUT: begin
								col_q <= col_d;
								row_q <= row_d;
								if (scroll) begin
									src_q   <= ROW_SPAN;
									state_q <= ST_COPY;
								end else begin
									state_q <= ST_DONE;
								end
							end
							FUNC_CLEAR: begin
								col_q   <= '0;
								row_q   <= '0;
								fill_q  <= '0;
								state_q <= ST_FILL;
							end
							FUNC_READ: begin
								state_q <= in_range ? ST_READ : ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_READ: begin
					data_q  <= mem_rdata;
					state_q <= ST_DONE;
				end
				ST_COPY: begin
					src_q <= src_q + 1'b1;
					if (src_q == CELL_LAST) begin
						fill_q  <= FILL_BASE;
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					if (!copy_pend_s1) begin
						fill_q <= fill_q + 1'b1;
						if (fill_q == CELL_LAST) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						loc_q   <= LOC_W'(cur_addr);
						cell_q  <= data_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* hdl/text_console_cursor_scroll.sv */
// Text console of ROWS x COLUMNS cells, each cell holding an attribute in
// the high byte and a character in the low byte.
// The cmd channel takes one word per operation: put a character, clear the
// screen, or read one cell. The rsp channel returns exactly one word per
// command, carrying the linear cursor location after the operation and, for
// a read, the cell contents (zero otherwise).
// The attribute register sits at byte address 0 of the APB-style port and
// colours both stored text and the blanks used for clearing and scrolling.
// Commands are handled one at a time; the screen memory's single write port
// sets the pace. A put that does not scroll, an unused function code or a
// read past the end of the screen goes from acceptance straight to the
// response state, and a read of a cell on the screen first passes through
// a read state. A put that runs past the last row copies every row up one,
// one cell per cycle, then blanks the bottom row. A clear blanks every cell.
// The next command is accepted as soon as the response has been placed in
// the output register, so one response may wait while the next command is
// worked on; a further result is held until the receiver takes the first.
// Reset homes the cursor and sets the attribute to white on black. The
// screen memory is not cleared: issue a clear before reading cells.
module text_console_cursor_scroll (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tcc_pkg::PADDR_W-1:0] paddr,
	input  logic [tcc_pkg::PDATA_W-1:0] pwdata,
	output logic [tcc_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	tcc_cmd_if.sink                     cmd,
	tcc_rsp_if.source                   rsp
);
	import tcc_pkg::*;

	logic [ATTR_W-1:0] attr_q;
	mem_req_t          mem_req;
	logic [CELL_W-1:0] mem_rdata;
	logic              reg_hit;

	// The port never inserts wait states. Only the word index of the address
	// is decoded, so any byte offset within the word reaches the register.
	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1:2] == REG_ATTR);
	assign prdata  = reg_hit ? PDATA_W'(attr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			attr_q <= pwdata[ATTR_W-1:0];
		end
	end

	// Sequencer: cursor state, scroll and clear sweeps, response register.
	tcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.attr      (attr_q),
		.cmd       (cmd),
		.rsp       (rsp),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	// Screen memory: one write and one registered read per cycle.
	tcc_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

endmodule

/* tb/tcc_checker.sv */
`timescale 1ns / 100ps

module tcc_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tcc_pkg::PADDR_W-1:0] paddr,
	input  logic [tcc_pkg::PDATA_W-1:0] pwdata,
	input  logic [tcc_pkg::PDATA_W-1:0] prdata,
	input  logic                        pready,
	tcc_cmd_if                          cmd,
	tcc_rsp_if                          rsp,
	output int                          failures,
	output int                          pending
);
	import tcc_pkg::*;

	typedef struct packed {
		logic [LOC_W-1:0]  location;
		logic [CELL_W-1:0] data;
	} console_word_t;

	// Shadow copy of the console: screen, cursor and attribute register.
	logic [CELL_W-1:0] screen [CELLS];
	int                col;
	int                row;
	logic [ATTR_W-1:0] attribute;
	console_word_t     expected_q [$];
	int                mismatches = 0;

	task automatic report(input string msg);
		$display("%0t checker: %s", $time, msg);
		mismatches++;
	endtask

	// Applies one command word to the shadow console and returns the word
	// that the console should answer with.
	function automatic console_word_t console_step(input logic [FUNC_W-1:0] op,
			input logic [CHAR_W-1:0] code, input logic [INDEX_W-1:0] index);
		console_word_t     result;
		logic [CELL_W-1:0] fill;
		fill = {attribute, BLANK_CHAR};
		result.data = '0;
		case (op)
		FUNC_PUT: begin
			if (code == CH_BS) begin
				if (col != 0)
					col--;
			end else if (code == CH_TAB) begin
				col = col + TAB_STOP - (col % TAB_STOP);
			end else if (code == CH_CR) begin
				col = 0;
			end else if (code == CH_LF) begin
				col = 0;
				row++;
			end else if (code >= CH_PRINT_LO && code <= CH_PRINT_HI) begin
				screen[row * COLUMNS + col] = {attribute, code};
				col++;
			end
			if (col >= COLUMNS) begin
				col = 0;
				row++;
			end
			// Past the last row: everything moves up one row.
			if (row >= ROWS) begin
				for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
					screen[i] = screen[i + COLUMNS];
				for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
					screen[i] = fill;
				row = ROWS - 1;
			end
		end
		FUNC_CLEAR: begin
			for (int i = 0; i < CELLS; i++)
				screen[i] = fill;
			col = 0;
			row = 0;
		end
		FUNC_READ: begin
			if (index < CELLS)
				result.data = screen[index];
		end
		default: ;
		endcase
		result.location = LOC_W'(row * COLUMNS + col);
		return result;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		console_word_t want;
		if (!arst_n) begin
			col = 0;
			row = 0;
			attribute = ATTR_RESET;
			expected_q.delete();
			pending <= 0;
			failures <= mismatches;
		end else begin
			if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_ATTR) begin
				if (pwrite)
					attribute = pwdata[ATTR_W-1:0];
				else if (prdata !== PDATA_W'(attribute))
					report($sformatf("attribute read back as %0h, expected %0h",
						prdata, attribute));
			end

			// A response can never belong to a command accepted at the same edge.
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					report($sformatf("response word %0h/%0h with no command waiting",
						rsp.cursor_pos, rsp.cell_data));
				end else begin
					want = expected_q.pop_front();
					if (rsp.cursor_pos !== want.location)
						report($sformatf("cursor position %0d, expected %0d",
							rsp.cursor_pos, want.location));
					if (rsp.cell_data !== want.data)
						report($sformatf("cell_data %0h, expected %0h",
							rsp.cell_data, want.data));
				end
			end

			if (cmd.valid && cmd.ready)
				expected_q.push_back(console_step(cmd.func, cmd.char_code, cmd.cell_index));

			pending <= expected_q.size();
			failures <= mismatches;
		end
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
	import tcc_pkg::*;

	// The function code that the console leaves unused: it must change nothing.
	localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
	// Byte address of the attribute register.
	localparam logic [PADDR_W-1:0] ATTR_ADDR = {REG_ATTR, 2'b00};
	// First cell of the two bottom rows, where text tends to end up after a scroll.
	localparam int LOW_ROWS_BASE = (ROWS - 2) * COLUMNS;
	localparam int INDEX_TOP     = 2 ** INDEX_W - 1;
	localparam int PHASES        = 5;
	localparam int PHASE_WORDS   = 170;
	// The limit assumes every word were as slow as a scroll or a clear, which sweep
	// the screen, and met the longest gaps and stalls, several times over.
	localparam int LIMIT         = 8_000_000;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int                 failures;
	int                 pending;
	int                 cycle_count;

	tcc_cmd_if cmd_bus ();
	tcc_rsp_if rsp_bus ();

	text_console_cursor_scroll DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cmd     (cmd_bus),
		.rsp     (rsp_bus)
	);

	// The checker keeps its own copy of the console, predicts every response
	// word and reports how many words are still owed and how many checks failed.
	tcc_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.cmd      (cmd_bus),
		.rsp      (rsp_bus),
		.failures (failures),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Global watchdog: a hung handshake must not keep the run going for ever.
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: FAIL");
		$finish;
	end

	// The receiver stalls on a pattern of its own: spans of steady readiness, spans of
	// coin tossing, spans in which it is mostly ready and spans in which it is mostly stalled.
	initial begin
		int mode;
		int span;
		rsp_bus.ready <= 1'b0;
		@(posedge clk);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(8, 80);
			repeat (span) begin
				case (mode)
				0: rsp_bus.ready <= 1'b1;
				1: rsp_bus.ready <= 1'($urandom_range(0, 1));
				2: rsp_bus.ready <= ($urandom_range(0, 7) == 0);
				default: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// Presents one command word and holds it until the console takes it. The
	// valid is left high, so a following word goes out back to back.
	task automatic send_cmd(input logic [FUNC_W-1:0] op, input logic [CHAR_W-1:0] code,
			input logic [INDEX_W-1:0] index);
		cmd_bus.valid      <= 1'b1;
		cmd_bus.func       <= op;
		cmd_bus.char_code  <= code;
		cmd_bus.cell_index <= index;
		do
			@(posedge clk);
		while (!cmd_bus.ready);
	endtask

	// One register transfer on the configuration port: setup, then access until
	// pready, then a return to idle so that the next transfer starts cleanly.
	task automatic apb_access(input logic write, input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= ATTR_ADDR;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// The checker's count is registered, so it lags the handshake; hence the edge first.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	// Draws one random command word. Most words are characters, with line feeds
	// frequent enough that the cursor reaches the bottom row and the screen
	// scrolls often; clears are rare so that the scrolling region is reached.
	// Reads lean towards the bottom rows and past the end of the screen.
	task automatic draw_cmd(output logic [FUNC_W-1:0] op, output logic [CHAR_W-1:0] code,
			output logic [INDEX_W-1:0] index);
		int pick;
		int kind;
		pick  = $urandom_range(0, 999);
		kind  = $urandom_range(0, 99);
		code  = CHAR_W'($urandom_range(0, 255));
		index = INDEX_W'($urandom_range(0, INDEX_TOP));
		if (pick < 4) begin
			op = FUNC_CLEAR;
		end else if (pick < 14) begin
			op = FUNC_SPARE;
		end else if (pick < 124) begin
			op = FUNC_READ;
			if (kind < 50)
				index = INDEX_W'($urandom_range(LOW_ROWS_BASE, INDEX_TOP));
		end else begin
			op = FUNC_PUT;
			if (kind < 55)
				code = CHAR_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
			else if (kind < 67)
				code = CH_LF;
			else if (kind < 75)
				code = CH_TAB;
			else if (kind < 81)
				code = CH_BS;
			else if (kind < 85)
				code = CH_CR;
			else if (kind < 91)
				code = CHAR_W'($urandom_range(CH_PRINT_HI + 1, 255));
			else
				code = CHAR_W'($urandom_range(0, CH_PRINT_LO - 1));
		end
	endtask

	initial begin
		logic [FUNC_W-1:0]  op;
		logic [CHAR_W-1:0]  code;
		logic [INDEX_W-1:0] index;
		logic [ATTR_W-1:0]  attr;
		int                 sent;
		int                 burst;
		int                 gap;

		arst_n             <= 1'b0;
		psel               <= 1'b0;
		penable            <= 1'b0;
		pwrite             <= 1'b0;
		paddr              <= '0;
		pwdata             <= '0;
		cmd_bus.valid      <= 1'b0;
		cmd_bus.func       <= FUNC_PUT;
		cmd_bus.char_code  <= '0;
		cmd_bus.cell_index <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The attribute must read back as its reset value before any write.
		apb_access(1'b0, '0);

		// Directed words, with the reset attribute. The screen memory holds
		// nothing defined until the first clear, so no cell is read before it.
		// Backspace first steps back over a character, then sits at column zero.
		send_cmd(FUNC_PUT, 8'h41, '0);
		send_cmd(FUNC_PUT, CH_BS, '0);
		send_cmd(FUNC_PUT, CH_BS, '0);
		send_cmd(FUNC_CLEAR, '0, '0);
		send_cmd(FUNC_READ, '0, '0);
		// Both ends of the printable range are stored; high codes and the
		// remaining control codes leave screen and cursor alone.
		send_cmd(FUNC_PUT, CH_PRINT_LO, '0);
		send_cmd(FUNC_PUT, CH_PRINT_HI, '0);
		send_cmd(FUNC_PUT, CH_PRINT_HI + 8'd1, '0);
		send_cmd(FUNC_PUT, 8'hFF, '0);
		send_cmd(FUNC_PUT, 8'h00, '0);
		send_cmd(FUNC_READ, '0, INDEX_W'(0));
		send_cmd(FUNC_READ, '0, INDEX_W'(1));
		send_cmd(FUNC_PUT, CH_CR, '0);
		send_cmd(FUNC_PUT, CH_LF, '0);
		// Last cell, first cell past the screen and the top of the index range.
		send_cmd(FUNC_READ, '0, INDEX_W'(CELLS - 1));
		send_cmd(FUNC_READ, '0, INDEX_W'(CELLS));
		send_cmd(FUNC_READ, 8'hFF, INDEX_W'(INDEX_TOP));
		send_cmd(FUNC_SPARE, 8'hFF, INDEX_W'(INDEX_TOP));
		// Tabs from column zero walk through every stop; the last one runs past
		// the final column and wraps to the start of the next row.
		repeat (COLUMNS / TAB_STOP)
			send_cmd(FUNC_PUT, CH_TAB, '0);
		cmd_bus.valid <= 1'b0;

		// Random phases, each under its own attribute. The attribute is only
		// changed once every response word of the previous phase has come back,
		// which also gives the full pause of the sender at least once.
		for (int phase = 0; phase < PHASES; phase++) begin
			wait_drained();
			case (phase)
			0: attr = 8'hFF;
			1: attr = 8'h00;
			default: attr = ATTR_W'($urandom_range(1, 254));
			endcase
			// The bits above the attribute byte carry junk which must be dropped.
			apb_access(1'b1, {PDATA_W'($urandom) >> ATTR_W << ATTR_W} | PDATA_W'(attr));
			apb_access(1'b0, '0);

			// Bursts of random length; about one gap in three is skipped, so
			// some bursts run straight into the next.
			sent = 0;
			while (sent < PHASE_WORDS) begin
				burst = $urandom_range(1, 16);
				for (int k = 0; k < burst && sent < PHASE_WORDS; k++) begin
					draw_cmd(op, code, index);
					send_cmd(op, code, index);
					sent++;
				end
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				if (gap != 0) begin
					cmd_bus.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			cmd_bus.valid <= 1'b0;
		end

		// Everything owed must arrive, and nothing more may follow it.
		wait_drained();
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
